@@ rtl/owm_pkg.sv @@
// Shared types, constants and helpers of the single-wire bus master.
`default_nettype none

package owm_pkg;

    localparam int TIME_BITS = 10;
    localparam int CFG_BITS  = 10;
    localparam int NUM_REGS  = 7;
    localparam int IDX_BITS  = 3;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_SLOT          = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SHORT_LOW     = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_RECOVERY      = 3'd6;

    // Register reset values
    localparam logic [CFG_BITS-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_BITS-1:0] RST_PRESENCE_WAIT = 10'd60;
    localparam logic [CFG_BITS-1:0] RST_RESET_TAIL    = 10'd480;
    localparam logic [CFG_BITS-1:0] RST_SLOT          = 10'd60;
    localparam logic [CFG_BITS-1:0] RST_SHORT_LOW     = 10'd1;
    localparam logic [CFG_BITS-1:0] RST_READ_LOW      = 10'd2;
    localparam logic [CFG_BITS-1:0] RST_RECOVERY      = 10'd1;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_TAIL  = 4'd3,
        PH_WR_LOW    = 4'd4,
        PH_WR_HIGH   = 4'd5,
        PH_WR_REC    = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_SAMPLE = 4'd8,
        PH_RD_WAIT   = 4'd9
    } t_phase;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

    // A timing of zero counts as one unit.
    function automatic logic [TIME_BITS-1:0] load_time(input logic [CFG_BITS-1:0] v);
        logic [TIME_BITS-1:0] t;
        t = v;
        if (t == '0) begin
            t = {{(TIME_BITS-1){1'b0}}, 1'b1};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/onewire_bus_master.sv @@
// Top level of the single-wire open-drain bus master.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_action, i_write_byte, i_line_in
// result    out        o_out_valid / i_out_ready o_drive_low, o_busy_res, o_done_res,
//                                                o_no_presence, o_read_byte, o_rejected
// config    in         i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_data
//
// Each input transaction is one bus time unit and yields exactly one result
// transaction. An accepted transaction updates the sequencer state in the same
// cycle and its result lands in a two-deep output buffer, so one transaction
// per cycle is sustained while the result side keeps up. o_in_ready drops only
// while both buffer entries are full. Reset is synchronous and active low; it
// restores the timing registers to their defaults and returns the sequencer to
// idle. Timing register writes take effect at the next phase that loads them.
module onewire_bus_master
    import owm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_action,
    input  wire logic [7:0]          i_write_byte,
    input  wire logic                i_line_in,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_drive_low,
    output logic                     o_busy_res,
    output logic                     o_done_res,
    output logic                     o_no_presence,
    output logic [7:0]               o_read_byte,
    output logic                     o_rejected,
    // configuration write port
    input  wire logic                i_cfg_wr_en,
    input  wire logic [IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0] i_cfg_data
);

    // Timing registers
    logic [CFG_BITS-1:0] r_cfg [NUM_REGS];

    // Sequencer state
    t_phase               r_phase,     n_phase;
    logic [TIME_BITS-1:0] r_time_left, n_time_left;
    logic [2:0]           r_bit_index, n_bit_index;
    logic [7:0]           r_shift,     n_shift;
    logic                 r_presence,  n_presence;
    t_op                  r_op,        n_op;

    // Output buffer: main register plus skid entry
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    // Per-transaction combinational values
    t_phase  w_phase_start;   // phase after a possible start command
    t_op     w_op_start;
    logic    w_finish;
    logic    w_rejected;
    t_result w_result;

    logic w_accept, w_pop;

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = r_out_valid && i_out_ready;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RESET_LOW]     <= RST_RESET_LOW;
            r_cfg[REG_PRESENCE_WAIT] <= RST_PRESENCE_WAIT;
            r_cfg[REG_RESET_TAIL]    <= RST_RESET_TAIL;
            r_cfg[REG_SLOT]          <= RST_SLOT;
            r_cfg[REG_SHORT_LOW]     <= RST_SHORT_LOW;
            r_cfg[REG_READ_LOW]      <= RST_READ_LOW;
            r_cfg[REG_RECOVERY]      <= RST_RECOVERY;
        end else if (i_cfg_wr_en && (i_cfg_index < IDX_BITS'(NUM_REGS))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Next-state logic: start handling first, then one time unit of the phase.
    always_comb begin
        t_phase               p0;
        logic [TIME_BITS-1:0] t0;
        logic [TIME_BITS-1:0] t_dec;
        logic [7:0]           sh0;
        logic [2:0]           bi0;
        t_op                  op0;
        logic                 pr0;
        logic                 next_bit;

        p0         = r_phase;
        t0         = r_time_left;
        t_dec      = '0;
        sh0        = r_shift;
        bi0        = r_bit_index;
        op0        = r_op;
        pr0        = r_presence;
        w_rejected = 1'b0;
        w_finish   = 1'b0;
        next_bit   = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (t_op'(i_action))
                OP_RESET: begin
                    op0 = OP_RESET;
                    pr0 = 1'b0;
                    p0  = PH_RST_LOW;
                    t0  = load_time(r_cfg[REG_RESET_LOW]);
                end
                OP_WRITE: begin
                    op0 = OP_WRITE;
                    sh0 = i_write_byte;
                    bi0 = '0;
                    p0  = PH_WR_LOW;
                    t0  = i_write_byte[0] ? load_time(r_cfg[REG_SHORT_LOW])
                                          : load_time(r_cfg[REG_SLOT]);
                end
                OP_READ: begin
                    op0 = OP_READ;
                    sh0 = '0;
                    bi0 = '0;
                    p0  = PH_RD_LOW;
                    t0  = load_time(r_cfg[REG_READ_LOW]);
                end
                default: begin
                end
            endcase
        end else begin
            w_rejected = (t_op'(i_action) != OP_NONE);
        end

        w_phase_start = p0;
        w_op_start    = op0;

        n_phase     = p0;
        n_time_left = t0;
        n_shift     = sh0;
        n_bit_index = bi0;
        n_op        = op0;
        n_presence  = pr0;

        if (p0 != PH_IDLE) begin
            if (p0 == PH_RD_SAMPLE && i_line_in) begin
                n_shift[bi0] = 1'b1;
            end
            t_dec       = t0 - 1'b1;
            n_time_left = t_dec;
            if (t_dec == '0) begin
                case (p0)
                    PH_RST_LOW: begin
                        n_phase     = PH_RST_WAIT;
                        n_time_left = load_time(r_cfg[REG_PRESENCE_WAIT]);
                    end
                    PH_RST_WAIT: begin
                        n_presence  = !i_line_in;
                        n_phase     = PH_RST_TAIL;
                        n_time_left = load_time(r_cfg[REG_RESET_TAIL]);
                    end
                    PH_WR_LOW: begin
                        if (sh0[bi0]) begin
                            n_phase     = PH_WR_HIGH;
                            n_time_left = load_time(r_cfg[REG_SLOT]);
                        end else begin
                            n_phase     = PH_WR_REC;
                            n_time_left = load_time(r_cfg[REG_RECOVERY]);
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase     = PH_RD_SAMPLE;
                        n_time_left = {{(TIME_BITS-1){1'b0}}, 1'b1};
                    end
                    PH_RD_SAMPLE: begin
                        n_phase     = PH_RD_WAIT;
                        n_time_left = load_time(r_cfg[REG_SLOT]);
                    end
                    PH_WR_HIGH, PH_WR_REC, PH_RD_WAIT: begin
                        next_bit = 1'b1;
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
                if (next_bit) begin
                    if (bi0 == LAST_BIT) begin
                        w_finish = 1'b1;
                    end else begin
                        n_bit_index = bi0 + 3'd1;
                        if (op0 == OP_WRITE) begin
                            n_phase     = PH_WR_LOW;
                            n_time_left = sh0[n_bit_index] ? load_time(r_cfg[REG_SHORT_LOW])
                                                           : load_time(r_cfg[REG_SLOT]);
                        end else begin
                            n_phase     = PH_RD_LOW;
                            n_time_left = load_time(r_cfg[REG_READ_LOW]);
                        end
                    end
                end
                if (w_finish) begin
                    n_phase     = PH_IDLE;
                    n_time_left = '0;
                end
            end
        end
    end

    // Result of the current time unit.
    always_comb begin
        w_result.drive_low   = (w_phase_start == PH_RST_LOW) ||
                               (w_phase_start == PH_WR_LOW)  ||
                               (w_phase_start == PH_RD_LOW);
        w_result.busy_res    = (n_phase != PH_IDLE);
        w_result.done_res    = w_finish;
        w_result.no_presence = w_finish && (w_op_start == OP_RESET) && !n_presence;
        w_result.read_byte   = (w_finish && (w_op_start == OP_READ)) ? n_shift : 8'd0;
        w_result.rejected    = w_rejected;
    end

    // Advance the sequencer once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_op        <= OP_NONE;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_time_left <= n_time_left;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_op        <= n_op;
        end
    end

    // Output buffer control: hold results in order, spill to skid on stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_low   = r_out.drive_low;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_no_presence = r_out.no_presence;
    assign o_read_byte   = r_out.read_byte;
    assign o_rejected    = r_out.rejected;

    // The skid entry is only used behind a full main register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // An active phase always has time left; idle has none.
    a_time_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) == (r_time_left != '0))
        else $error("time counter inconsistent with phase");

    // A finishing transaction returns the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_finish) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after done");

    // A rejected command never disturbs the running operation.
    a_reject_keeps_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_rejected) |=> (r_op == $past(r_op)))
        else $error("rejected command changed the operation");

endmodule

`default_nettype wire

@@ tb/sv/onewire_bus_master_tb.sv @@
// Self-checking testbench for the single-wire bus master: directed table, then random bus traffic.
`timescale 1ns / 1ps

module onewire_bus_master_tb
    import owm_pkg::*;
();

    localparam int STALL_CYCLES = 60;

    typedef logic [CFG_BITS-1:0] t_timing_set [NUM_REGS];

    // One row of the directed table. Rows with check_typed set carry their
    // expected result inline; the others are checked against the predictor.
    typedef struct {
        t_op        act;
        logic [7:0] wb;
        logic       line;
        bit         check_typed;
        t_result    want;
    } t_unit_row;

    localparam t_result FROM_PREDICTOR = '0;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_op                 act_in;
    logic [7:0]          wb_in;
    logic                line_in;
    logic                out_valid;
    logic                out_ready;
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic                no_presence;
    logic [7:0]          read_byte;
    logic                rejected;
    logic                cfg_wr_en;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    onewire_bus_master dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (act_in),
        .i_write_byte  (wb_in),
        .i_line_in     (line_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_drive_low   (drive_low),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_no_presence (no_presence),
        .o_read_byte   (read_byte),
        .o_rejected    (rejected),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer predictor: its own copy of the timing registers and state
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]  timing_reg [NUM_REGS];
    t_phase               bus_phase;
    logic [TIME_BITS-1:0] units_left;
    logic [2:0]           bit_pos;
    logic [7:0]           data_shift;
    logic                 device_answered;
    t_op                  cur_op;

    t_result     pending_results [$];
    t_unit_row   directed_units [24];
    int          errors;
    int          results_checked;
    int          units_sent;
    int          rejects_seen;
    int          settings_used;
    int          op_starts [4];
    bit          calm;           // no idling on either side while set
    bit          stall_request;  // ask the receiver for one long hold-off
    int          line_mode;      // line pattern for the current operation

    // Load a phase timer; a count of zero behaves as one unit.
    function automatic void set_phase(t_phase p, logic [TIME_BITS-1:0] units);
        bus_phase  = p;
        units_left = (units == '0) ? TIME_BITS'(1) : units;
    endfunction

    // Open the slot of the current bit of a write or a read.
    function automatic void start_bit();
        if (cur_op == OP_WRITE) begin
            set_phase(PH_WR_LOW, data_shift[bit_pos] ? timing_reg[REG_SHORT_LOW]
                                                     : timing_reg[REG_SLOT]);
        end else begin
            set_phase(PH_RD_LOW, timing_reg[REG_READ_LOW]);
        end
    endfunction

    // Advance the predicted sequencer by one bus time unit.
    function automatic void predict_unit(input t_op act, input logic [7:0] wb,
                                         input logic line, output t_result r);
        bit next_bit;
        bit finish;
        r = '0;
        if (bus_phase == PH_IDLE) begin
            case (act)
                OP_RESET: begin
                    cur_op          = OP_RESET;
                    device_answered = 1'b0;
                    set_phase(PH_RST_LOW, timing_reg[REG_RESET_LOW]);
                end
                OP_WRITE: begin
                    cur_op     = OP_WRITE;
                    data_shift = wb;
                    bit_pos    = '0;
                    start_bit();
                end
                OP_READ: begin
                    cur_op     = OP_READ;
                    data_shift = '0;
                    bit_pos    = '0;
                    start_bit();
                end
                default: ;
            endcase
        end else if (act != OP_NONE) begin
            r.rejected = 1'b1;
        end

        if (bus_phase != PH_IDLE) begin
            r.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                          (bus_phase == PH_RD_LOW);
            if (bus_phase == PH_RD_SAMPLE && line) begin
                data_shift[bit_pos] = 1'b1;
            end
            if (units_left != '0) begin
                units_left--;
            end
            if (units_left == '0) begin
                next_bit = 1'b0;
                finish   = 1'b0;
                case (bus_phase)
                    PH_RST_LOW:  set_phase(PH_RST_WAIT, timing_reg[REG_PRESENCE_WAIT]);
                    PH_RST_WAIT: begin
                        // a device pulls the line low to announce itself
                        device_answered = !line;
                        set_phase(PH_RST_TAIL, timing_reg[REG_RESET_TAIL]);
                    end
                    PH_RST_TAIL: finish = 1'b1;
                    PH_WR_LOW: begin
                        if (data_shift[bit_pos]) begin
                            set_phase(PH_WR_HIGH, timing_reg[REG_SLOT]);
                        end else begin
                            set_phase(PH_WR_REC, timing_reg[REG_RECOVERY]);
                        end
                    end
                    PH_RD_LOW:    set_phase(PH_RD_SAMPLE, TIME_BITS'(1));
                    PH_RD_SAMPLE: set_phase(PH_RD_WAIT, timing_reg[REG_SLOT]);
                    PH_WR_HIGH, PH_WR_REC, PH_RD_WAIT: next_bit = 1'b1;
                    default: finish = 1'b1;
                endcase
                if (next_bit) begin
                    if (bit_pos == LAST_BIT) begin
                        finish = 1'b1;
                    end else begin
                        bit_pos++;
                        start_bit();
                    end
                end
                if (finish) begin
                    r.done_res = 1'b1;
                    if (cur_op == OP_RESET) r.no_presence = !device_answered;
                    if (cur_op == OP_READ)  r.read_byte   = data_shift;
                    bus_phase  = PH_IDLE;
                    units_left = '0;
                end
            end
        end
        r.busy_res = (bus_phase != PH_IDLE);
    endfunction

    function automatic t_result outcome(bit drv, bit busy, bit done, bit nopres,
                                        logic [7:0] rb, bit rej);
        t_result r;
        r.drive_low   = drv;
        r.busy_res    = busy;
        r.done_res    = done;
        r.no_presence = nopres;
        r.read_byte   = rb;
        r.rejected    = rej;
        return r;
    endfunction

    function automatic t_timing_set pick_timings(int lo, int hi);
        t_timing_set v;
        foreach (v[r]) v[r] = CFG_BITS'($urandom_range(lo, hi));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one bus time unit per transaction
    // ------------------------------------------------------------------
    // Offer one unit, hold it until accepted, then advance the predictor and
    // queue the expectation. Valid stays high when the next unit follows at once.
    task automatic send_item(input t_op act, input logic [7:0] wb, input logic line,
                             input bit check_typed, input t_result want);
        t_result r;
        if (!calm) begin
            while ($urandom_range(0, 99) < 29) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        act_in   <= act;
        wb_in    <= wb;
        line_in  <= line;
        do @(posedge clk); while (!in_ready);
        if (bus_phase == PH_IDLE && act != OP_NONE) op_starts[act]++;
        predict_unit(act, wb, line, r);
        if (r.rejected) rejects_seen++;
        pending_results.push_back(check_typed ? want : r);
        units_sent++;
    endtask

    // Write all timing registers back to back; the block is idle meanwhile.
    task automatic load_timings(input t_timing_set vals);
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= IDX_BITS'(r);
            cfg_data  <= vals[r];
            @(posedge clk);
            timing_reg[r] = vals[r];
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Tick the bus until the running operation ends, then drain the results.
    task automatic finish_and_drain();
        while (bus_phase != PH_IDLE) begin
            send_item(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, FROM_PREDICTOR);
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed operations with random content; while busy, drop in
    // an occasional start command that must be rejected.
    task automatic run_random(input int n_items, input int max_ops, input int stall_at);
        int         ops;
        t_op        act;
        logic [7:0] wb;
        logic       line;
        ops = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i == stall_at) stall_request = 1'b1;
            act = OP_NONE;
            if (bus_phase == PH_IDLE) begin
                if (ops < max_ops && $urandom_range(0, 99) < 75) begin
                    act       = t_op'($urandom_range(1, 3));
                    line_mode = $urandom_range(0, 3);
                    ops++;
                end
            end else if ($urandom_range(0, 99) < 6) begin
                act = t_op'($urandom_range(1, 3));
            end
            if ($urandom_range(0, 9) == 0) begin
                wb = {8{1'($urandom_range(0, 1))}};
            end else begin
                wb = 8'($urandom_range(0, 255));
            end
            // hold the line high or low through a whole operation now and then,
            // so reads assemble all-ones and all-zeros bytes
            case (line_mode)
                2:       line = 1'b1;
                3:       line = 1'b0;
                default: line = 1'($urandom_range(0, 1));
            endcase
            send_item(act, wb, line, 1'b0, FROM_PREDICTOR);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each result transaction with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    t_result oldest;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $error("result transaction with no input transaction pending");
            end else begin
                oldest = pending_results.pop_front();
                check_field("drive_low",   oldest.drive_low,   drive_low);
                check_field("busy_res",    oldest.busy_res,    busy_res);
                check_field("done_res",    oldest.done_res,    done_res);
                check_field("no_presence", oldest.no_presence, no_presence);
                check_field("read_byte",   oldest.read_byte,   read_byte);
                check_field("rejected",    oldest.rejected,    rejected);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        act_in    <= OP_NONE;
        wb_in     <= '0;
        line_in   <= 1'b1;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_RESET_LOW;
        cfg_data  <= '0;

        errors          = 0;
        results_checked = 0;
        units_sent      = 0;
        rejects_seen    = 0;
        settings_used   = 0;
        op_starts       = '{default: 0};
        calm            = 1'b0;
        stall_request   = 1'b0;
        line_mode       = 0;

        // predictor state after reset
        timing_reg[REG_RESET_LOW]     = RST_RESET_LOW;
        timing_reg[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
        timing_reg[REG_RESET_TAIL]    = RST_RESET_TAIL;
        timing_reg[REG_SLOT]          = RST_SLOT;
        timing_reg[REG_SHORT_LOW]     = RST_SHORT_LOW;
        timing_reg[REG_READ_LOW]      = RST_READ_LOW;
        timing_reg[REG_RECOVERY]      = RST_RECOVERY;
        bus_phase       = PH_IDLE;
        units_left      = '0;
        bit_pos         = '0;
        data_shift      = '0;
        device_answered = 1'b0;
        cur_op          = OP_NONE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Shortest timings; reset low, short low and recovery at zero act as one.
        // Order: reset low, presence wait, reset tail, slot, short low, read low,
        // recovery.
        load_timings('{10'd0, 10'd1, 10'd1, 10'd1, 10'd0, 10'd1, 10'd0});

        directed_units = '{
            // idle after reset
            '{OP_NONE,  8'h00, 1'b1, 1'b1, outcome(0, 0, 0, 0, 8'h00, 0)},
            // reset pulse, device answers
            '{OP_RESET, 8'hFF, 1'b1, 1'b1, outcome(1, 1, 0, 0, 8'h00, 0)},
            '{OP_NONE,  8'h00, 1'b0, 1'b0, FROM_PREDICTOR},
            // start during the reset tail: rejected, reset completes with presence
            '{OP_WRITE, 8'h00, 1'b0, 1'b1, outcome(0, 0, 1, 0, 8'h00, 1)},
            // reset pulse, nobody answers
            '{OP_RESET, 8'h00, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'hFF, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h00, 1'b1, 1'b1, outcome(0, 0, 1, 1, 8'h00, 0)},
            // write all ones; a read start in its second unit is rejected
            '{OP_WRITE, 8'hFF, 1'b1, 1'b1, outcome(1, 1, 0, 0, 8'h00, 0)},
            '{OP_READ,  8'h00, 1'b0, 1'b1, outcome(0, 1, 0, 0, 8'h00, 1)},
            '{OP_NONE,  8'h01, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h02, 1'b0, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h04, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h08, 1'b0, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h10, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_RESET, 8'h20, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h40, 1'b0, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h80, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'hAA, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h55, 1'b0, 1'b0, FROM_PREDICTOR},
            '{OP_WRITE, 8'h3C, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'hC3, 1'b1, 1'b0, FROM_PREDICTOR},
            '{OP_NONE,  8'h00, 1'b1, 1'b0, FROM_PREDICTOR},
            // last released slot of bit seven ends the write
            '{OP_NONE,  8'hFF, 1'b1, 1'b1, outcome(0, 0, 1, 0, 8'h00, 0)},
            // read opens with its low phase; the random part carries it on
            '{OP_READ,  8'hA5, 1'b1, 1'b1, outcome(1, 1, 0, 0, 8'h00, 0)}
        };
        foreach (directed_units[k]) begin
            send_item(directed_units[k].act, directed_units[k].wb, directed_units[k].line,
                      directed_units[k].check_typed, directed_units[k].want);
        end

        // same timings; the receiver holds off once so the output buffer fills
        run_random(140, 1000, 100);
        finish_and_drain();

        // short timings, no idling on either side
        load_timings(pick_timings(1, 4));
        calm = 1'b1;
        run_random(140, 1000, -1);
        calm = 1'b0;
        finish_and_drain();

        // short timings with zeros mixed in
        load_timings(pick_timings(0, 12));
        run_random(140, 1000, -1);
        finish_and_drain();

        // reset low phase at its maximum: one full-length reset, rejects on top
        load_timings('{10'd1023, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1});
        line_mode = 0;
        send_item(OP_RESET, 8'($urandom_range(0, 255)), 1'b1, 1'b0, FROM_PREDICTOR);
        run_random(40, 0, -1);
        finish_and_drain();

        // moderate timings
        load_timings(pick_timings(1, 24));
        run_random(140, 1000, -1);
        finish_and_drain();

        // back to the low extreme
        load_timings(pick_timings(0, 2));
        run_random(140, 1000, -1);
        finish_and_drain();

        repeat (8) @(posedge clk);

        $display("covered %0d bus units under %0d timing settings, %0d results checked",
                 units_sent, settings_used, results_checked);
        $display("operations started: %0d resets, %0d writes, %0d reads; %0d starts rejected",
                 op_starts[OP_RESET], op_starts[OP_WRITE], op_starts[OP_READ], rejects_seen);
        if (errors == 0) begin
            $display("onewire_bus_master_tb passed");
        end else begin
            $display("onewire_bus_master_tb failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("onewire_bus_master_tb failed");
        $finish;
    end

endmodule
